// ----- src/sme_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, opcodes and sizes for the stack machine executor.
// No dependencies; imported by every module of the block.
package sme_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int WORD_W      = 32;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int DEPTH_OUT_W = 8;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [7:0] OPC_HALT  = 8'd0;
  localparam logic [7:0] OPC_PUSH  = 8'd1;
  localparam logic [7:0] OPC_ADD   = 8'd2;
  localparam logic [7:0] OPC_SUB   = 8'd3;
  localparam logic [7:0] OPC_MUL   = 8'd4;
  localparam logic [7:0] OPC_DIV   = 8'd5;
  localparam logic [7:0] OPC_MOD   = 8'd6;
  localparam logic [7:0] OPC_RDINT = 8'd7;
  localparam logic [7:0] OPC_WRINT = 8'd8;
  localparam logic [7:0] OPC_RDCHR = 8'd9;
  localparam logic [7:0] OPC_WRCHR = 8'd10;

  typedef enum logic [3:0] {
    K_NOP, K_HALT, K_PUSH, K_ADD, K_SUB, K_MUL, K_DIV, K_MOD, K_WRITE
  } instr_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_OVER  = 2'd1,
    ERR_UNDER = 2'd2,
    ERR_DIVZ  = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_EXEC, ST_DIV
  } back_state_e;

  typedef struct packed {
    instr_kind_e         kind;
    logic                is_char;
    logic [WORD_W-1:0]   value;
    logic                last;
  } instr_t;

  typedef struct packed {
    logic              start;
    logic              is_mod;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } div_rsp_t;

  typedef struct packed {
    logic                   out_valid;
    logic                   out_is_char;
    logic [WORD_W-1:0]      out_value;
    logic                   halted;
    err_e                   error;
    logic [DEPTH_OUT_W-1:0] stack_depth;
  } result_t;

endpackage

// ----- src/sme_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input words, decodes the opcode and operand, and holds
// decoded instructions in a short queue for the back end. Uses sme_pkg.
module sme_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  logic [7:0]      cmd_i,
  input  logic [23:0]     immediate_i,
  input  logic [31:0]     read_value_i,
  input  logic            end_of_program_i,
  output logic            q_valid_o,
  output sme_pkg::instr_t q_word_o,
  input  logic            q_pop_i
);
  import sme_pkg::*;

  instr_t              dec;
  instr_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                acc, pop;

  always_comb begin
    dec.kind    = K_NOP;
    dec.is_char = 1'b0;
    dec.value   = read_value_i;
    dec.last    = end_of_program_i;
    case (cmd_i)
      OPC_HALT: dec.kind = K_HALT;
      OPC_PUSH: begin
        dec.kind  = K_PUSH;
        dec.value = {{8{immediate_i[23]}}, immediate_i};
      end
      OPC_ADD:   dec.kind = K_ADD;
      OPC_SUB:   dec.kind = K_SUB;
      OPC_MUL:   dec.kind = K_MUL;
      OPC_DIV:   dec.kind = K_DIV;
      OPC_MOD:   dec.kind = K_MOD;
      OPC_RDINT: dec.kind = K_PUSH;
      OPC_RDCHR: begin
        dec.kind  = K_PUSH;
        dec.value = {{24{read_value_i[7]}}, read_value_i[7:0]};
      end
      OPC_WRINT: dec.kind = K_WRITE;
      OPC_WRCHR: begin
        dec.kind    = K_WRITE;
        dec.is_char = 1'b1;
      end
      default: dec.kind = K_NOP;
    endcase
  end

  assign full_o    = (cnt_q == QCNT_W'(QDEPTH));
  assign q_valid_o = (cnt_q != '0);
  assign q_word_o  = slot_q[rd_q];
  assign acc       = push_i && !full_o;
  assign pop       = q_pop_i && q_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (acc && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !acc) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= '0;
      rd_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (acc) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      slot_q[wr_q] <= dec;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !pop) |=> (cnt_q == $past(cnt_q) + QCNT_W'(1)))
    else $error("queue count lost a word");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("queue pointers disagree with empty count");

endmodule

// ----- src/sme_div.sv -----
`timescale 1ns / 1ps
// Iterative signed divider, one quotient bit per cycle, truncating quotient
// or remainder. Uses sme_pkg.
module sme_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sme_pkg::div_req_t req_i,
  output sme_pkg::div_rsp_t rsp_o
);
  import sme_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy_q, fin_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [WORD_W-1:0] quot_q, rem_q, dvs_q, res_q;
  logic              neg_q, is_mod_q;
  logic [WORD_W:0]   shifted, trial;
  logic [WORD_W-1:0] mag;

  assign shifted = {rem_q, quot_q[WORD_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign mag     = is_mod_q ? rem_q : quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(WORD_W - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q   <= req_i.dividend[WORD_W-1] ? -req_i.dividend : req_i.dividend;
      dvs_q    <= req_i.divisor[WORD_W-1] ? -req_i.divisor : req_i.divisor;
      rem_q    <= '0;
      is_mod_q <= req_i.is_mod;
      neg_q    <= req_i.is_mod ? req_i.dividend[WORD_W-1]
                               : (req_i.dividend[WORD_W-1] ^ req_i.divisor[WORD_W-1]);
    end else if (busy_q) begin
      if (!trial[WORD_W]) begin
        rem_q  <= trial[WORD_W-1:0];
        quot_q <= {quot_q[WORD_W-2:0], 1'b1};
      end else begin
        rem_q  <= shifted[WORD_W-1:0];
        quot_q <= {quot_q[WORD_W-2:0], 1'b0};
      end
    end else if (fin_q) begin
      res_q <= neg_q ? -mag : mag;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q || fin_q) |-> !req_i.start)
    else $error("divider started while busy");
  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> done_q)
    else $error("divider finish did not signal done");
  a_phase_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && fin_q))
    else $error("divider busy and finishing at once");

endmodule

// ----- src/sme_back.sv -----
`timescale 1ns / 1ps
// Back end: executes decoded instructions on the operand stack (top entry in
// a register, the rest in memory) and holds one result word. Uses sme_pkg, sme_div.
module sme_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  sme_pkg::instr_t  q_word_i,
  output logic             q_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output sme_pkg::result_t res_o
);
  import sme_pkg::*;

  back_state_e       state_q, state_d;
  instr_t            ins_q;
  logic [SP_W-1:0]   sp_q, sp_d;
  logic [WORD_W-1:0] tos_q, tos_d;
  logic              stop_q, stop_d;
  result_t           res_q, res_d;
  logic              res_valid_q, res_valid_d;

  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic              take;
  logic [WORD_W-1:0] alu;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  sme_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign take    = (state_q == ST_IDLE) && q_valid_i && (!res_valid_q || pop_i);
  assign q_pop_o = take;
  assign empty_o = !res_valid_q;
  assign res_o   = res_q;

  always_comb begin
    case (ins_q.kind)
      K_ADD:   alu = rdata_q + tos_q;
      K_SUB:   alu = rdata_q - tos_q;
      default: alu = rdata_q * tos_q;
    endcase
  end

  always_comb begin
    state_d          = state_q;
    sp_d             = sp_q;
    tos_d            = tos_q;
    stop_d           = stop_q;
    res_d            = res_q;
    res_valid_d      = res_valid_q && !pop_i;
    mem_we           = 1'b0;
    mem_waddr        = IDX_W'(sp_q - SP_W'(1));
    div_req.start    = 1'b0;
    div_req.is_mod   = (ins_q.kind == K_MOD);
    div_req.dividend = rdata_q;
    div_req.divisor  = tos_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_d.out_valid   = 1'b0;
        res_d.out_is_char = 1'b0;
        res_d.out_value   = '0;
        res_d.error       = ERR_NONE;
        state_d           = ST_IDLE;
        if (!stop_q) begin
          case (ins_q.kind)
            K_HALT: stop_d = 1'b1;
            K_PUSH: begin
              if (sp_q >= SP_W'(STACK_DEPTH)) begin
                res_d.error = ERR_OVER;
              end else begin
                mem_we = (sp_q != '0);
                tos_d  = ins_q.value;
                sp_d   = sp_q + SP_W'(1);
              end
            end
            K_ADD, K_SUB, K_MUL: begin
              if (sp_q < SP_W'(2)) begin
                res_d.error = ERR_UNDER;
              end else begin
                tos_d = alu;
                sp_d  = sp_q - SP_W'(1);
              end
            end
            K_DIV, K_MOD: begin
              if (sp_q < SP_W'(2)) begin
                res_d.error = ERR_UNDER;
              end else if (tos_q == '0) begin
                res_d.error = ERR_DIVZ;
              end else begin
                div_req.start = 1'b1;
                state_d       = ST_DIV;
              end
            end
            K_WRITE: begin
              if (sp_q == '0) begin
                res_d.error = ERR_UNDER;
              end else begin
                res_d.out_valid   = 1'b1;
                res_d.out_is_char = ins_q.is_char;
                res_d.out_value   = tos_q;
                tos_d             = rdata_q;
                sp_d              = sp_q - SP_W'(1);
              end
            end
            default: ;
          endcase
          if (res_d.error != ERR_NONE || ins_q.last) begin
            stop_d = 1'b1;
          end
        end
        if (state_d == ST_IDLE) begin
          res_valid_d       = 1'b1;
          res_d.halted      = stop_d;
          res_d.stack_depth = DEPTH_OUT_W'(sp_d);
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          tos_d             = div_rsp.result;
          sp_d              = sp_q - SP_W'(1);
          stop_d            = stop_q | ins_q.last;
          res_valid_d       = 1'b1;
          res_d.out_valid   = 1'b0;
          res_d.out_is_char = 1'b0;
          res_d.out_value   = '0;
          res_d.error       = ERR_NONE;
          res_d.halted      = stop_q | ins_q.last;
          res_d.stack_depth = DEPTH_OUT_W'(sp_q - SP_W'(1));
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sp_q        <= '0;
      stop_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      stop_q      <= stop_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    res_q <= res_d;
    if (take) begin
      ins_q <= q_word_i;
    end
  end

  // stack memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= tos_q;
    end
    if (take) begin
      rdata_q <= mem[IDX_W'(sp_q - SP_W'(2))];
    end
  end

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q)
    else $error("stopped machine restarted");
  a_stopped_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && stop_q) |=> $stable(sp_q))
    else $error("stopped machine changed the stack");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !pop_i) |=> (res_valid_q && $stable(res_q)))
    else $error("pending result overwritten");
  a_take_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> !res_valid_q || (state_q == ST_EXEC))
    else $error("instruction taken without a free result slot");

endmodule

// ----- src/stack_machine_executor.sv -----
`timescale 1ns / 1ps
// Stack machine executor top level: a 32-bit operand stack interpreter.
// Depends on sme_pkg, sme_front, sme_back (which holds sme_div).
//
// Usage:
//   Instruction words enter through push/full: a word is taken at a rising
//   edge with push high and full low. Up to two decoded words queue ahead
//   of execution, so the source keeps pushing while a result is pending.
//   Each instruction yields exactly one result word, shown on the result ports
//   while empty is low and taken at an edge with pop high.
// Execution:
//   Stack, arithmetic and I/O instructions pass a registered stack memory
//   read, then execute. Div and mod run an iterative divider at one
//   quotient bit per cycle. The executor takes a new instruction only
//   once the previous one has finished.
// Reset:
//   Clears the stack pointer, the halt flag, the queue and the result slot;
//   stack contents are not cleared. No clearing pass is needed.
// Stall:
//   While a result waits unpopped, execution holds; once the two queue slots
//   fill, full rises until the receiver pops.
module stack_machine_executor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  cmd_i,
  input  logic [23:0] immediate_i,
  input  logic [31:0] read_value_i,
  input  logic        end_of_program_i,
  output logic        empty,
  input  logic        pop,
  output logic        out_valid_o,
  output logic        out_is_char_o,
  output logic [31:0] out_value_o,
  output logic        halted_o,
  output logic [1:0]  error_o,
  output logic [7:0]  stack_depth_o
);
  import sme_pkg::*;

  logic    q_valid, q_pop;
  instr_t  q_word;
  result_t res;

  sme_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_o           (full),
    .cmd_i            (cmd_i),
    .immediate_i      (immediate_i),
    .read_value_i     (read_value_i),
    .end_of_program_i (end_of_program_i),
    .q_valid_o        (q_valid),
    .q_word_o         (q_word),
    .q_pop_i          (q_pop)
  );

  sme_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_word_i  (q_word),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .res_o     (res)
  );

  assign out_valid_o   = res.out_valid;
  assign out_is_char_o = res.out_is_char;
  assign out_value_o   = res.out_value;
  assign halted_o      = res.halted;
  assign error_o       = res.error;
  assign stack_depth_o = res.stack_depth;

endmodule
